[rtl/core/atw_pkg.sv]
// ----------------------------------------------------------------------------
// atw_pkg
// Shared types, codes and helpers for the ATA task-file command writer:
// request encoding, divider stage state and the one-bit CHS divide step.
// ----------------------------------------------------------------------------
package atw_pkg;

  // field widths
  localparam int ATW_BLOCK_W    = 28;
  localparam int ATW_DIV_BITS   = 4;
  localparam int ATW_DIV_STAGES = ATW_BLOCK_W / ATW_DIV_BITS;

  // request actions
  typedef enum logic [1:0] {
    ATW_ACT_LBA   = 2'd0,
    ATW_ACT_CHS   = 2'd1,
    ATW_ACT_BASIC = 2'd2,
    ATW_ACT_XLATE = 2'd3
  } atw_action_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    ATW_REG_PRI_BASE = 2'd0,
    ATW_REG_SEC_BASE = 2'd1,
    ATW_REG_SPT      = 2'd2,
    ATW_REG_HPC      = 2'd3
  } atw_reg_e;

  // what a queued request turns into on the output
  typedef enum logic [1:0] {
    ATW_K_CMD    = 2'd0,
    ATW_K_NOTRDY = 2'd1,
    ATW_K_XLATE  = 2'd2
  } atw_kind_e;

  // register reset values
  localparam logic [15:0] ATW_PRI_BASE_RST = 16'h01F0;
  localparam logic [15:0] ATW_SEC_BASE_RST = 16'h0170;
  localparam logic [5:0]  ATW_SPT_RST      = 6'd63;
  localparam logic [4:0]  ATW_HPC_RST      = 5'd16;
  localparam logic [4:0]  ATW_HPC_MAX      = 5'd16;

  // task-file constants
  localparam logic [7:0]  ATW_DH_LBA     = 8'hE0;
  localparam logic [7:0]  ATW_DH_CHS     = 8'hA0;
  localparam logic [3:0]  ATW_NIBBLE     = 4'hF;
  localparam logic [7:0]  ATW_STAT_BUSY  = 8'h80;
  localparam logic [7:0]  ATW_STAT_READY = 8'h40;
  localparam logic [15:0] ATW_OFS_CNT    = 16'd2;

  // write slots: count, sector, cyl low, cyl high, drive/head, command
  localparam int          ATW_NBYTES    = 6;
  localparam logic [2:0]  ATW_IDX_FIRST = 3'd0;
  localparam logic [2:0]  ATW_IDX_DRVHD = 3'd4;
  localparam logic [2:0]  ATW_IDX_LAST  = 3'd5;

  typedef struct packed {
    atw_kind_e                   kind;
    logic                        chan;
    logic [2:0]                  start;
    logic [ATW_NBYTES-1:0][7:0]  bytes;
  } atw_req_t;

  typedef struct packed {
    logic [ATW_BLOCK_W-1:0] work;
    logic [5:0]             rem_spt;
    logic [3:0]             rem_hpc;
    atw_req_t               req;
  } atw_div_t;

  typedef struct packed {
    logic       qbit;
    logic [5:0] rem_spt;
    logic [3:0] rem_hpc;
  } atw_step_t;

  // one restoring step of block/spt chained into one step of (block/spt)/hpc
  function automatic atw_step_t atw_div_step(logic nbit, logic [5:0] rem_spt,
                                             logic [5:0] spt, logic [3:0] rem_hpc,
                                             logic [4:0] hpc);
    logic [6:0] t1;
    logic [4:0] t2;
    logic       q1;
    atw_step_t  res;
    t1 = {rem_spt, nbit};
    q1 = (t1 >= {1'b0, spt});
    res.rem_spt = q1 ? 6'(t1 - {1'b0, spt}) : t1[5:0];
    t2 = {rem_hpc, q1};
    res.qbit = (t2 >= hpc);
    res.rem_hpc = res.qbit ? 4'(t2 - hpc) : t2[3:0];
    return res;
  endfunction

endpackage

[rtl/core/atw_chs_div.sv]
// ----------------------------------------------------------------------------
// atw_chs_div
// Pipelined block to CHS divider. Each stage retires four dividend bits of
// block / spt and feeds the quotient bits straight into (block / spt) / hpc.
// The request side data rides along; valid/stall handshake on both ends.
// ----------------------------------------------------------------------------
module atw_chs_div
  import atw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [5:0]             spt_i,
  input  logic [4:0]             hpc_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ATW_BLOCK_W-1:0] in_dividend_i,
  input  atw_req_t               in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ATW_BLOCK_W-1:0] out_quot_o,
  output logic [5:0]             out_rem_spt_o,
  output logic [3:0]             out_rem_hpc_o,
  output atw_req_t               out_req_o
);

  logic [ATW_DIV_STAGES-1:0] valid_q;
  atw_div_t                  stage_q [ATW_DIV_STAGES];
  logic [ATW_DIV_STAGES-1:0] src_valid;
  atw_div_t                  src     [ATW_DIV_STAGES];
  atw_div_t                  stage_d [ATW_DIV_STAGES];
  logic [ATW_DIV_STAGES-1:0] take;
  logic [ATW_DIV_STAGES-1:0] load;

  // stage sources
  always_comb begin
    src_valid[0] = in_valid_i;
    src[0].work    = in_dividend_i;
    src[0].rem_spt = '0;
    src[0].rem_hpc = '0;
    src[0].req     = in_req_i;
    for (int s = 1; s < ATW_DIV_STAGES; s++) begin
      src_valid[s] = valid_q[s-1];
      src[s]       = stage_q[s-1];
    end
  end

  // backward flow control: a stage loads when empty or when it hands on
  always_comb begin
    take[ATW_DIV_STAGES-1] = valid_q[ATW_DIV_STAGES-1] & ~out_stall_i;
    load[ATW_DIV_STAGES-1] = ~valid_q[ATW_DIV_STAGES-1] | take[ATW_DIV_STAGES-1];
    for (int s = ATW_DIV_STAGES - 2; s >= 0; s--) begin
      take[s] = valid_q[s] & load[s+1];
      load[s] = ~valid_q[s] | take[s];
    end
  end

  // four divide steps per stage
  always_comb begin
    atw_step_t st;
    st = '0;
    for (int s = 0; s < ATW_DIV_STAGES; s++) begin
      stage_d[s] = src[s];
      for (int j = 0; j < ATW_DIV_BITS; j++) begin
        st = atw_div_step(stage_d[s].work[ATW_BLOCK_W-1], stage_d[s].rem_spt, spt_i,
                          stage_d[s].rem_hpc, hpc_i);
        stage_d[s].work    = {stage_d[s].work[ATW_BLOCK_W-2:0], st.qbit};
        stage_d[s].rem_spt = st.rem_spt;
        stage_d[s].rem_hpc = st.rem_hpc;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < ATW_DIV_STAGES; s++) begin
        if (load[s]) begin
          valid_q[s] <= src_valid[s];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < ATW_DIV_STAGES; s++) begin
      if (load[s] && src_valid[s]) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign in_stall_o    = ~load[0];
  assign out_valid_o   = valid_q[ATW_DIV_STAGES-1];
  assign out_quot_o    = stage_q[ATW_DIV_STAGES-1].work;
  assign out_rem_spt_o = stage_q[ATW_DIV_STAGES-1].rem_spt;
  assign out_rem_hpc_o = stage_q[ATW_DIV_STAGES-1].rem_hpc;
  assign out_req_o     = stage_q[ATW_DIV_STAGES-1].req;

endmodule

[rtl/core/ata_taskfile_command_writer_top.sv]
// ----------------------------------------------------------------------------
// ata_taskfile_command_writer_top
// Turns one command request into its ATA task-file port writes or a not-ready
// flag, or a block number into cylinder/head/sector from the configured geometry.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) takes one request per
//   transaction. The output channel (out_valid_o / out_stall_i) gives one
//   result per transaction: LBA and CHS commands give six port writes,
//   a basic command two, and translate or a not-ready status one.
//   Every request passes a seven stage divider pipeline, then a one-entry
//   request register and the output register. The output port carries one
//   result per cycle while out_stall_i is low; the next request is loaded
//   behind the last result of the previous one without a gap. Up to nine
//   requests are in flight.
//   A stall on the output holds the result registers and fills the pipeline
//   back to the input, which then stalls; nothing is dropped or repeated.
//   Reset empties the pipeline and sets the base addresses to 0x1F0 and
//   0x170 and the geometry to 63 sectors and 16 heads. Configuration is
//   written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write
//   it only while the block idles, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ata_taskfile_command_writer_top
  import atw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  drive_i,
  input  logic [27:0] block_i,
  input  logic [7:0]  sector_count_i,
  input  logic [7:0]  opcode_i,
  input  logic [15:0] cylinder_in_i,
  input  logic [3:0]  head_in_i,
  input  logic [7:0]  sector_in_i,
  input  logic [7:0]  device_status_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] port_address_o,
  output logic [7:0]  port_data_o,
  output logic        last_o,
  output logic        not_ready_o,
  output logic [15:0] cylinder_out_o,
  output logic [3:0]  head_out_o,
  output logic [5:0]  sector_out_o,
  output logic        chs_overflow_o
);

  typedef struct packed {
    atw_req_t    req;
    logic [15:0] cyl;
    logic [3:0]  head;
    logic [5:0]  sect;
    logic        ovf;
  } atw_cur_t;

  logic [15:0] pri_base_q;
  logic [15:0] sec_base_q;
  logic [5:0]  spt_q;
  logic [4:0]  hpc_q;
  logic [5:0]  spt_eff;
  logic [4:0]  hpc_eff;

  atw_req_t    in_req;
  logic        status_ok;
  logic [7:0]  sel_bits;

  logic        div_valid;
  logic        div_stall;
  logic [27:0] div_quot;
  logic [5:0]  div_rem_spt;
  logic [3:0]  div_rem_hpc;
  atw_req_t    div_req;

  logic        cur_valid_q;
  atw_cur_t    cur_q;
  atw_cur_t    cur_d;
  logic [2:0]  idx_q;
  logic        cur_last;
  logic        div_take;
  logic        out_free;
  logic        emit;

  logic        out_valid_q;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        last_q, last_d;
  logic        nrdy_q, nrdy_d;
  logic [15:0] cyl_q, cyl_d;
  logic [3:0]  head_q, head_d;
  logic [5:0]  sect_q, sect_d;
  logic        ovf_q, ovf_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pri_base_q <= ATW_PRI_BASE_RST;
      sec_base_q <= ATW_SEC_BASE_RST;
      spt_q      <= ATW_SPT_RST;
      hpc_q      <= ATW_HPC_RST;
    end else if (cfg_we_i) begin
      case (atw_reg_e'(cfg_idx_i))
        ATW_REG_PRI_BASE: pri_base_q <= cfg_data_i;
        ATW_REG_SEC_BASE: sec_base_q <= cfg_data_i;
        ATW_REG_SPT:      spt_q      <= cfg_data_i[5:0];
        ATW_REG_HPC:      hpc_q      <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // geometry clamped to usable divisors
  always_comb begin
    spt_eff = (spt_q == '0) ? 6'd1 : spt_q;
    if (hpc_q == '0) begin
      hpc_eff = 5'd1;
    end else if (hpc_q > ATW_HPC_MAX) begin
      hpc_eff = ATW_HPC_MAX;
    end else begin
      hpc_eff = hpc_q;
    end
  end

  // request encoding: task-file bytes in write order
  always_comb begin
    status_ok = ((device_status_i & (ATW_STAT_BUSY | ATW_STAT_READY)) == ATW_STAT_READY);
    sel_bits  = {3'b000, drive_i[0], 4'b0000};
    in_req.chan     = drive_i[1];
    in_req.start    = ATW_IDX_FIRST;
    in_req.bytes[0] = sector_count_i;
    in_req.bytes[5] = opcode_i;
    in_req.bytes[1] = sector_in_i;
    in_req.bytes[2] = cylinder_in_i[7:0];
    in_req.bytes[3] = cylinder_in_i[15:8];
    in_req.bytes[4] = ATW_DH_CHS | sel_bits | {4'b0000, head_in_i & ATW_NIBBLE};
    case (atw_action_e'(action_i))
      ATW_ACT_LBA: begin
        in_req.bytes[1] = block_i[7:0];
        in_req.bytes[2] = block_i[15:8];
        in_req.bytes[3] = block_i[23:16];
        in_req.bytes[4] = ATW_DH_LBA | sel_bits | {4'b0000, block_i[27:24] & ATW_NIBBLE};
      end
      ATW_ACT_BASIC: begin
        in_req.start    = ATW_IDX_DRVHD;
        in_req.bytes[4] = ATW_DH_CHS | sel_bits;
      end
      default: ;
    endcase
    if (atw_action_e'(action_i) == ATW_ACT_XLATE) begin
      in_req.kind = ATW_K_XLATE;
    end else if (!status_ok) begin
      in_req.kind = ATW_K_NOTRDY;
    end else begin
      in_req.kind = ATW_K_CMD;
    end
  end

  // block to chs divider pipeline
  atw_chs_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .spt_i         (spt_eff),
    .hpc_i         (hpc_eff),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_dividend_i (block_i),
    .in_req_i      (in_req),
    .out_valid_o   (div_valid),
    .out_stall_i   (div_stall),
    .out_quot_o    (div_quot),
    .out_rem_spt_o (div_rem_spt),
    .out_rem_hpc_o (div_rem_hpc),
    .out_req_o     (div_req)
  );

  // translate results with cylinder saturation
  always_comb begin
    cur_d.req  = div_req;
    cur_d.ovf  = |div_quot[27:16];
    cur_d.cyl  = cur_d.ovf ? 16'hFFFF : div_quot[15:0];
    cur_d.head = div_rem_hpc;
    cur_d.sect = 6'(div_rem_spt + 6'd1);
  end

  // request sequencing
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign emit     = cur_valid_q & out_free;
  assign cur_last = (cur_q.req.kind != ATW_K_CMD) || (idx_q == ATW_IDX_LAST);
  assign div_take = ~cur_valid_q | (emit & cur_last);
  assign div_stall = ~div_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= ATW_IDX_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (div_take) begin
        cur_valid_q <= div_valid;
        idx_q       <= div_req.start;
      end else if (emit) begin
        idx_q <= 3'(idx_q + 3'd1);
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_take && div_valid) begin
      cur_q <= cur_d;
    end
  end

  // next result from the current request
  always_comb begin
    addr_d = '0;
    data_d = '0;
    last_d = 1'b1;
    nrdy_d = 1'b0;
    cyl_d  = '0;
    head_d = '0;
    sect_d = '0;
    ovf_d  = 1'b0;
    case (cur_q.req.kind)
      ATW_K_CMD: begin
        addr_d = 16'((cur_q.req.chan ? sec_base_q : pri_base_q) + ATW_OFS_CNT
                     + {13'd0, idx_q});
        data_d = cur_q.req.bytes[idx_q];
        last_d = (idx_q == ATW_IDX_LAST);
      end
      ATW_K_NOTRDY: begin
        nrdy_d = 1'b1;
      end
      ATW_K_XLATE: begin
        cyl_d  = cur_q.cyl;
        head_d = cur_q.head;
        sect_d = cur_q.sect;
        ovf_d  = cur_q.ovf;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= last_d;
      nrdy_q <= nrdy_d;
      cyl_q  <= cyl_d;
      head_q <= head_d;
      sect_q <= sect_d;
      ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign port_address_o = addr_q;
  assign port_data_o    = data_q;
  assign last_o         = last_q;
  assign not_ready_o    = nrdy_q;
  assign cylinder_out_o = cyl_q;
  assign head_out_o     = head_q;
  assign sector_out_o   = sect_q;
  assign chs_overflow_o = ovf_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ATA task-file command writer. Requests go in
// through the valid/stall channel. A behavioral predictor turns each accepted
// request into the port writes, the not-ready flag or the CHS translation it
// should produce. Every result is checked field by field, oldest first.
// Geometry and base addresses are changed between phases while the block is
// idle. The last phases hold the output back long enough for the input to
// stall, then run with no idle cycles at all.
// ----------------------------------------------------------------------------
module tb_top;
  import atw_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  // task-file register offsets from the channel base
  localparam logic [15:0] OFS_SECTOR   = 16'd3;
  localparam logic [15:0] OFS_CYL_LO   = 16'd4;
  localparam logic [15:0] OFS_CYL_HI   = 16'd5;
  localparam logic [15:0] OFS_DRV_HEAD = 16'd6;
  localparam logic [15:0] OFS_COMMAND  = 16'd7;

  typedef struct {
    atw_action_e action;
    logic [1:0]  drive;
    logic [27:0] block;
    logic [7:0]  count;
    logic [7:0]  opcode;
    logic [15:0] cyl;
    logic [3:0]  head;
    logic [7:0]  sector;
    logic [7:0]  status;
  } ata_request_t;

  typedef struct {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        last;
    logic        not_ready;
    logic [15:0] cyl;
    logic [3:0]  head;
    logic [5:0]  sector;
    logic        ovf;
  } port_write_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = ATW_REG_PRI_BASE;
  logic [15:0] cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i        = ATW_ACT_LBA;
  logic [1:0]  drive_i         = '0;
  logic [27:0] block_i         = '0;
  logic [7:0]  sector_count_i  = '0;
  logic [7:0]  opcode_i        = '0;
  logic [15:0] cylinder_in_i   = '0;
  logic [3:0]  head_in_i       = '0;
  logic [7:0]  sector_in_i     = '0;
  logic [7:0]  device_status_i = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [15:0] port_address_o;
  logic [7:0]  port_data_o;
  logic        last_o;
  logic        not_ready_o;
  logic [15:0] cylinder_out_o;
  logic [3:0]  head_out_o;
  logic [5:0]  sector_out_o;
  logic        chs_overflow_o;

  // predictor copy of the configuration
  logic [15:0] pri_base = ATW_PRI_BASE_RST;
  logic [15:0] sec_base = ATW_SEC_BASE_RST;
  logic [5:0]  geo_spt  = ATW_SPT_RST;
  logic [4:0]  geo_hpc  = ATW_HPC_RST;

  port_write_t expected_writes[$];
  int          mismatch_count = 0;
  bit          idling_on      = 1'b1;
  bit          hold_request   = 1'b0;

  ata_taskfile_command_writer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .drive_i         (drive_i),
    .block_i         (block_i),
    .sector_count_i  (sector_count_i),
    .opcode_i        (opcode_i),
    .cylinder_in_i   (cylinder_in_i),
    .head_in_i       (head_in_i),
    .sector_in_i     (sector_in_i),
    .device_status_i (device_status_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .port_address_o  (port_address_o),
    .port_data_o     (port_data_o),
    .last_o          (last_o),
    .not_ready_o     (not_ready_o),
    .cylinder_out_o  (cylinder_out_o),
    .head_out_o      (head_out_o),
    .sector_out_o    (sector_out_o),
    .chs_overflow_o  (chs_overflow_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // one result with the translate fields cleared
  function automatic port_write_t port_write(input logic [15:0] addr, input logic [7:0] data,
                                             input logic last);
    port_write_t w;
    w.addr      = addr;
    w.data      = data;
    w.last      = last;
    w.not_ready = 1'b0;
    w.cyl       = '0;
    w.head      = '0;
    w.sector    = '0;
    w.ovf       = 1'b0;
    return w;
  endfunction

  // expected results of one accepted request
  function automatic void predict_taskfile(input ata_request_t req);
    logic [15:0] base;
    logic [7:0]  sel;
    int unsigned spt_eff;
    int unsigned hpc_eff;
    int unsigned cyl;
    port_write_t w;
    base = req.drive[1] ? sec_base : pri_base;
    sel  = {3'b000, req.drive[0], 4'h0};
    if (req.action == ATW_ACT_XLATE) begin
      // translate ignores status; degenerate geometry is clamped
      spt_eff = (geo_spt == 6'd0) ? 1 : geo_spt;
      hpc_eff = (geo_hpc == 5'd0) ? 1 : (geo_hpc > ATW_HPC_MAX) ? ATW_HPC_MAX : geo_hpc;
      cyl = req.block / (spt_eff * hpc_eff);
      w = port_write('0, '0, 1'b1);
      w.ovf    = (cyl > 32'hFFFF);
      w.cyl    = w.ovf ? 16'hFFFF : cyl[15:0];
      w.head   = 4'((req.block / spt_eff) % hpc_eff);
      w.sector = 6'((req.block % spt_eff) + 1);
      expected_writes.push_back(w);
    end else if ((req.status & (ATW_STAT_BUSY | ATW_STAT_READY)) != ATW_STAT_READY) begin
      w = port_write('0, '0, 1'b1);
      w.not_ready = 1'b1;
      expected_writes.push_back(w);
    end else if (req.action == ATW_ACT_BASIC) begin
      expected_writes.push_back(port_write(base + OFS_DRV_HEAD, ATW_DH_CHS | sel, 1'b0));
      expected_writes.push_back(port_write(base + OFS_COMMAND, req.opcode, 1'b1));
    end else begin
      expected_writes.push_back(port_write(base + ATW_OFS_CNT, req.count, 1'b0));
      if (req.action == ATW_ACT_LBA) begin
        expected_writes.push_back(port_write(base + OFS_SECTOR, req.block[7:0], 1'b0));
        expected_writes.push_back(port_write(base + OFS_CYL_LO, req.block[15:8], 1'b0));
        expected_writes.push_back(port_write(base + OFS_CYL_HI, req.block[23:16], 1'b0));
        expected_writes.push_back(port_write(base + OFS_DRV_HEAD,
                                             ATW_DH_LBA | sel | {4'h0, req.block[27:24]}, 1'b0));
      end else begin
        expected_writes.push_back(port_write(base + OFS_SECTOR, req.sector, 1'b0));
        expected_writes.push_back(port_write(base + OFS_CYL_LO, req.cyl[7:0], 1'b0));
        expected_writes.push_back(port_write(base + OFS_CYL_HI, req.cyl[15:8], 1'b0));
        expected_writes.push_back(port_write(base + OFS_DRV_HEAD,
                                             ATW_DH_CHS | sel | {4'h0, req.head}, 1'b0));
      end
      expected_writes.push_back(port_write(base + OFS_COMMAND, req.opcode, 1'b1));
    end
  endfunction

  function automatic ata_request_t make_request(input atw_action_e action,
                                                input logic [1:0] drive,
                                                input logic [27:0] block,
                                                input logic [7:0] count, input logic [7:0] opcode,
                                                input logic [15:0] cyl, input logic [3:0] head,
                                                input logic [7:0] sector,
                                                input logic [7:0] status);
    ata_request_t r;
    r.action = action;
    r.drive  = drive;
    r.block  = block;
    r.count  = count;
    r.opcode = opcode;
    r.cyl    = cyl;
    r.head   = head;
    r.sector = sector;
    r.status = status;
    return r;
  endfunction

  // mostly ready requests; block spread over small, large and full range
  function automatic ata_request_t random_request();
    ata_request_t r;
    r.action = atw_action_e'($urandom_range(0, 3));
    r.drive  = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       r.block = 28'($urandom());
      1:       r.block = 28'($urandom_range(0, 4095));
      2:       r.block = 28'hFFFFFFF - 28'($urandom_range(0, 4095));
      default: r.block = 28'($urandom_range(0, 2000000));
    endcase
    r.count  = 8'($urandom());
    r.opcode = 8'($urandom());
    r.cyl    = 16'($urandom());
    r.head   = 4'($urandom());
    r.sector = 8'($urandom());
    r.status = 8'($urandom());
    if ($urandom_range(0, 4) != 0) begin
      r.status = (r.status & ~ATW_STAT_BUSY) | ATW_STAT_READY;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // one request transaction; prediction is made when it is taken
  task automatic send_request(input ata_request_t req);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    action_i        <= req.action;
    drive_i         <= req.drive;
    block_i         <= req.block;
    sector_count_i  <= req.count;
    opcode_i        <= req.opcode;
    cylinder_in_i   <= req.cyl;
    head_in_i       <= req.head;
    sector_in_i     <= req.sector;
    device_status_i <= req.status;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_taskfile(req);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input atw_reg_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
  endtask

  // all four registers, written only while idle
  task automatic set_geometry(input logic [15:0] pri, input logic [15:0] sec,
                              input logic [5:0] spt, input logic [4:0] hpc);
    cfg_write(ATW_REG_PRI_BASE, pri);
    cfg_write(ATW_REG_SEC_BASE, sec);
    cfg_write(ATW_REG_SPT, {10'h0, spt});
    cfg_write(ATW_REG_HPC, {11'h0, hpc});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pri_base = pri;
    sec_base = sec;
    geo_spt  = spt;
    geo_hpc  = hpc;
  endtask

  // output stall: random bursts, or one long hold on request
  initial begin : out_stall_gen
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    port_write_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, address %0h", port_address_o));
      end else begin
        want = expected_writes.pop_front();
        check_field("port_address", 32'(port_address_o), 32'(want.addr));
        check_field("port_data", 32'(port_data_o), 32'(want.data));
        check_field("last", 32'(last_o), 32'(want.last));
        check_field("not_ready", 32'(not_ready_o), 32'(want.not_ready));
        check_field("cylinder_out", 32'(cylinder_out_o), 32'(want.cyl));
        check_field("head_out", 32'(head_out_o), 32'(want.head));
        check_field("sector_out", 32'(sector_out_o), 32'(want.sector));
        check_field("chs_overflow", 32'(chs_overflow_o), 32'(want.ovf));
      end
    end
  end

  // end the run when no transaction moves for too long
  int quiet_cycles = 0;
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // reset configuration, every action and both kinds of not-ready status
  task automatic test_reset_defaults();
    send_request(make_request(ATW_ACT_LBA, 2'd0, 28'h0123456, 8'h01, 8'h20,
                              16'h0, 4'h0, 8'h00, 8'h50));
    send_request(make_request(ATW_ACT_CHS, 2'd1, 28'h0, 8'h10, 8'h30,
                              16'hABCD, 4'h9, 8'h11, 8'h40));
    send_request(make_request(ATW_ACT_BASIC, 2'd2, 28'h0, 8'h00, 8'hEC,
                              16'h0, 4'h0, 8'h00, 8'h58));
    send_request(make_request(ATW_ACT_XLATE, 2'd3, 28'd100000, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h00));
    send_request(make_request(ATW_ACT_LBA, 2'd0, 28'h1, 8'h01, 8'h20,
                              16'h0, 4'h0, 8'h00, 8'hD0));
    send_request(make_request(ATW_ACT_CHS, 2'd3, 28'h0, 8'h01, 8'h20,
                              16'h1, 4'h1, 8'h01, 8'h00));
    send_request(make_request(ATW_ACT_BASIC, 2'd1, 28'h0, 8'h00, 8'hEC,
                              16'h0, 4'h0, 8'h00, 8'hC0));
    drain_results();
  endtask

  // field extremes, base address wrap, overflow and clamped geometry
  task automatic test_directed_extremes();
    set_geometry(16'h0000, 16'hFFFF, 6'd1, 5'd1);
    send_request(make_request(ATW_ACT_LBA, 2'd3, 28'hFFFFFFF, 8'hFF, 8'hFF,
                              16'hFFFF, 4'hF, 8'hFF, 8'h7F));
    send_request(make_request(ATW_ACT_CHS, 2'd2, 28'hFFFFFFF, 8'hFF, 8'h00,
                              16'hFFFF, 4'hF, 8'hFF, 8'h40));
    send_request(make_request(ATW_ACT_LBA, 2'd0, 28'h0, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    send_request(make_request(ATW_ACT_XLATE, 2'd0, 28'hFFFFFFF, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'hFF));
    send_request(make_request(ATW_ACT_XLATE, 2'd1, 28'd65535, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    send_request(make_request(ATW_ACT_XLATE, 2'd2, 28'd65536, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    send_request(make_request(ATW_ACT_BASIC, 2'd3, 28'h0, 8'h00, 8'hA5,
                              16'h0, 4'h0, 8'h00, 8'h40));
    drain_results();
    // zero sectors and zero heads are both used as one
    set_geometry(16'hFFFF, 16'h0000, 6'd0, 5'd0);
    send_request(make_request(ATW_ACT_XLATE, 2'd0, 28'd12345, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    send_request(make_request(ATW_ACT_LBA, 2'd1, 28'h9876543, 8'h5A, 8'hC8,
                              16'h0, 4'h0, 8'h00, 8'h40));
    send_request(make_request(ATW_ACT_BASIC, 2'd0, 28'h0, 8'h00, 8'h91,
                              16'h0, 4'h0, 8'h00, 8'h40));
    drain_results();
    // heads above sixteen are used as sixteen
    set_geometry(ATW_PRI_BASE_RST, ATW_SEC_BASE_RST, 6'd63, 5'd31);
    send_request(make_request(ATW_ACT_XLATE, 2'd0, 28'hFFFFFFF, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    send_request(make_request(ATW_ACT_XLATE, 2'd0, 28'd1007, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    send_request(make_request(ATW_ACT_XLATE, 2'd0, 28'd1008, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    drain_results();
    set_geometry(16'h1234, 16'h8000, 6'd17, 5'd17);
    send_request(make_request(ATW_ACT_XLATE, 2'd0, 28'd5000, 8'h00, 8'h00,
                              16'h0, 4'h0, 8'h00, 8'h40));
    drain_results();
  endtask

  // random requests over a few geometries, with idling on both sides
  task automatic test_random_traffic();
    set_geometry(16'($urandom()), 16'($urandom()), 6'($urandom_range(1, 63)),
                 5'($urandom_range(1, 16)));
    repeat (27) send_request(random_request());
    drain_results();
    set_geometry(ATW_PRI_BASE_RST, ATW_SEC_BASE_RST, ATW_SPT_RST, ATW_HPC_RST);
    repeat (27) send_request(random_request());
    drain_results();
    set_geometry(16'($urandom()), 16'($urandom()), 6'($urandom_range(0, 63)),
                 5'($urandom_range(0, 31)));
    repeat (27) send_request(random_request());
    drain_results();
  endtask

  // long output hold while requests keep coming, so the input stalls
  task automatic test_backpressure();
    idling_on    = 1'b0;
    hold_request = 1'b1;
    repeat (30) send_request(random_request());
    drain_results();
  endtask

  // back to back traffic with no idle cycles
  task automatic test_streaming_no_idle();
    idling_on = 1'b0;
    repeat (20) send_request(random_request());
    drain_results();
  endtask

  initial begin : run_tests
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_traffic();
    test_backpressure();
    test_streaming_no_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
